// ===== design/vfla_pkg.sv =====
// Shared types, codes and default constants of the connection identifier allocator.
// Depends on nothing; every other file of the allocator imports it.
package vfla_pkg;

    localparam int VCI_W        = 12;
    localparam int FUNC_W       = 2;
    localparam int STAT_W       = 2;
    localparam int THR_W        = 13;
    localparam int CFG_DATA_W   = 13;
    localparam int CFG_IDX_W    = 1;

    localparam int VCI_SPACE_DEF    = 4096;
    localparam int REFILL_BATCH_DEF = 64;

    localparam logic [VCI_W-1:0] VCI_BASE_RST   = 12'd31;
    localparam logic [THR_W-1:0] REFILL_THR_RST = 13'd16;

    localparam logic [CFG_IDX_W-1:0] CFG_VCI_BASE   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REFILL_THR = 1'd1;

    localparam logic [FUNC_W-1:0] FUNC_ALLOC    = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_SPECIFIC = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_RETURN   = 2'd2;

    typedef enum logic [STAT_W-1:0] {
        RSP_GRANTED  = 2'd0,
        RSP_REFUSED  = 2'd1,
        RSP_RETURNED = 2'd2,
        RSP_IGNORED  = 2'd3
    } rsp_status_t;

    typedef enum logic [1:0] {
        VS_NEVER = 2'd0,
        VS_FREE  = 2'd1,
        VS_USED  = 2'd2
    } vci_state_t;

    typedef enum logic [1:0] {
        RD_CURSOR = 2'd0,
        RD_HEAD   = 2'd1,
        RD_VCI    = 2'd2
    } rd_sel_t;

    typedef enum logic [1:0] {
        ACT_APPEND_NEVER = 2'd0,
        ACT_APPEND_USED  = 2'd1,
        ACT_UNLINK_ANY   = 2'd2,
        ACT_UNLINK_FREE  = 2'd3
    } act_kind_t;

    typedef struct packed {
        logic      load;
        logic      rd;
        rd_sel_t   rd_sel;
        logic      act;
        act_kind_t act_kind;
        logic      ref_start;
        logic      cur_inc;
        logic      clr;
        logic      res_refuse;
        logic      out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic              need_refill;
        logic              cursor_lt_stop;
        logic              list_nonempty;
        logic              clr_last;
    } dp_sts_t;

endpackage

// ===== design/vfla_req_if.sv =====
// Request channel of the allocator: valid, ready and the request payload.
// Depends on vfla_pkg for the field widths.
interface vfla_req_if import vfla_pkg::*;;
    logic              valid;
    logic              ready;
    logic [FUNC_W-1:0] func;
    logic [VCI_W-1:0]  vci;

    modport source (output valid, output func, output vci, input ready);
    modport sink (input valid, input func, input vci, output ready);
endinterface

// ===== design/vfla_rsp_if.sv =====
// Response channel of the allocator: valid, ready and the response payload.
// Depends on vfla_pkg for the field widths.
interface vfla_rsp_if import vfla_pkg::*;;
    logic              valid;
    logic              ready;
    logic [VCI_W-1:0]  granted_vci;
    logic [STAT_W-1:0] status;

    modport source (output valid, output granted_vci, output status, input ready);
    modport sink (input valid, input granted_vci, input status, output ready);
endinterface

// ===== design/vfla_dp.sv =====
// Datapath of the allocator: status and link memories, list registers, refill cursor,
// configuration registers and the result registers. Depends on vfla_pkg.
module vfla_dp import vfla_pkg::*;
#(
    parameter int VCI_SPACE    = VCI_SPACE_DEF,
    parameter int REFILL_BATCH = REFILL_BATCH_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic [FUNC_W-1:0]     in_func,
    input  logic [VCI_W-1:0]      in_vci,
    input  dp_cmd_t               cmd,
    output dp_sts_t               sts,
    output logic [VCI_W-1:0]      out_vci,
    output logic [STAT_W-1:0]     out_status
);

    localparam int IW  = $clog2(VCI_SPACE);
    localparam int CW  = $clog2(VCI_SPACE + 1);
    localparam int NUW = (CW > THR_W) ? CW : THR_W;
    localparam int SW  = NUW + 1;
    localparam int TW  = (CW > THR_W) ? CW : THR_W;

    logic [1:0]    status_mem [VCI_SPACE];
    logic [IW-1:0] next_mem   [VCI_SPACE];
    logic [IW-1:0] prev_mem   [VCI_SPACE];

    logic [THR_W-1:0]  thr_reg;
    logic [IW-1:0]     head_reg, head_next;
    logic [IW-1:0]     tail_reg, tail_next;
    logic [CW-1:0]     count_reg, count_next;
    logic [NUW-1:0]    nu_reg;
    logic [NUW-1:0]    cursor_reg;
    logic [NUW-1:0]    stop_reg;
    logic [IW-1:0]     clr_reg;
    logic [FUNC_W-1:0] func_reg;
    logic [VCI_W-1:0]  vci_reg;
    logic [IW-1:0]     op_addr_reg;
    logic [1:0]        status_q_reg;
    logic [IW-1:0]     next_q_reg;
    logic [IW-1:0]     prev_q_reg;
    logic [VCI_W-1:0]  res_vci_reg;
    logic [STAT_W-1:0] res_status_reg;
    logic [VCI_W-1:0]  out_vci_reg;
    logic [STAT_W-1:0] out_status_reg;

    logic [IW-1:0]  rd_addr;
    logic [IW-1:0]  vci_idx;
    logic           vci_ok;
    logic           cond;
    logic           is_append;
    logic [SW-1:0]  stop_sum;
    logic [NUW-1:0] stop_calc;
    logic           st_we;
    logic [IW-1:0]  st_wa;
    logic [1:0]     st_wd;
    logic           nx_we;
    logic [IW-1:0]  nx_wa;
    logic [IW-1:0]  nx_wd;
    logic           pv_we;
    logic [IW-1:0]  pv_wa;
    logic [IW-1:0]  pv_wd;

    assign vci_idx  = IW'(vci_reg);
    assign vci_ok   = (32'(vci_reg) < VCI_SPACE);
    assign stop_sum = SW'(nu_reg) + SW'(REFILL_BATCH);
    assign stop_calc = (stop_sum > SW'(VCI_SPACE)) ? NUW'(VCI_SPACE) : NUW'(stop_sum);
    assign is_append = (cmd.act_kind == ACT_APPEND_NEVER) || (cmd.act_kind == ACT_APPEND_USED);

    always_comb
    begin
        case (cmd.rd_sel)
            RD_CURSOR: rd_addr = cursor_reg[IW-1:0];
            RD_HEAD:   rd_addr = head_reg;
            RD_VCI:    rd_addr = vci_idx;
            default:   rd_addr = head_reg;
        endcase
    end

    always_comb
    begin
        case (cmd.act_kind)
            ACT_APPEND_NEVER: cond = (status_q_reg == VS_NEVER);
            ACT_APPEND_USED:  cond = vci_ok && (status_q_reg == VS_USED);
            ACT_UNLINK_ANY:   cond = 1'b1;
            ACT_UNLINK_FREE:  cond = vci_ok && (status_q_reg == VS_FREE);
            default:          cond = 1'b0;
        endcase
    end

    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        st_we = 1'b0;
        st_wa = op_addr_reg;
        st_wd = VS_NEVER;
        nx_we = 1'b0;
        nx_wa = tail_reg;
        nx_wd = op_addr_reg;
        pv_we = 1'b0;
        pv_wa = op_addr_reg;
        pv_wd = tail_reg;
        if (cmd.clr)
        begin
            st_we = 1'b1;
            st_wa = clr_reg;
            st_wd = VS_NEVER;
        end
        else if (cmd.act && cond)
        begin
            st_we = 1'b1;
            if (is_append)
            begin
                st_wd = VS_FREE;
                if (count_reg == '0)
                begin
                    head_next = op_addr_reg;
                end
                else
                begin
                    nx_we = 1'b1;
                    nx_wa = tail_reg;
                    nx_wd = op_addr_reg;
                    pv_we = 1'b1;
                    pv_wa = op_addr_reg;
                    pv_wd = tail_reg;
                end
                tail_next  = op_addr_reg;
                count_next = count_reg + CW'(1);
            end
            else
            begin
                st_wd = VS_USED;
                if (count_reg <= CW'(1))
                begin
                    head_next  = '0;
                    tail_next  = '0;
                    count_next = '0;
                end
                else
                begin
                    if (op_addr_reg == head_reg)
                    begin
                        head_next = next_q_reg;
                    end
                    else
                    begin
                        nx_we = 1'b1;
                        nx_wa = prev_q_reg;
                        nx_wd = next_q_reg;
                    end
                    if (op_addr_reg == tail_reg)
                    begin
                        tail_next = prev_q_reg;
                    end
                    else
                    begin
                        pv_we = 1'b1;
                        pv_wa = next_q_reg;
                        pv_wd = prev_q_reg;
                    end
                    count_next = count_reg - CW'(1);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        status_q_reg <= status_mem[rd_addr];
        next_q_reg   <= next_mem[rd_addr];
        prev_q_reg   <= prev_mem[rd_addr];
        if (st_we)
        begin
            status_mem[st_wa] <= st_wd;
        end
        if (nx_we)
        begin
            next_mem[nx_wa] <= nx_wd;
        end
        if (pv_we)
        begin
            prev_mem[pv_wa] <= pv_wd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg    <= REFILL_THR_RST;
            nu_reg     <= NUW'(VCI_BASE_RST) + NUW'(1);
            head_reg   <= '0;
            tail_reg   <= '0;
            count_reg  <= '0;
            cursor_reg <= '0;
            stop_reg   <= '0;
            clr_reg    <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
            if (cmd.clr)
            begin
                clr_reg <= clr_reg + IW'(1);
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_VCI_BASE:
                    begin
                        nu_reg <= NUW'(cfg_data[VCI_W-1:0]) + NUW'(1);
                    end
                    CFG_REFILL_THR:
                    begin
                        thr_reg <= cfg_data[THR_W-1:0];
                    end
                    default:
                    begin
                        thr_reg <= thr_reg;
                    end
                endcase
            end
            else if (cmd.ref_start)
            begin
                cursor_reg <= nu_reg;
                stop_reg   <= stop_calc;
                nu_reg     <= stop_calc;
            end
            else if (cmd.cur_inc)
            begin
                cursor_reg <= cursor_reg + NUW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            func_reg <= in_func;
            vci_reg  <= in_vci;
        end
        if (cmd.rd)
        begin
            op_addr_reg <= rd_addr;
        end
        if (cmd.res_refuse)
        begin
            res_vci_reg    <= '0;
            res_status_reg <= RSP_REFUSED;
        end
        else if (cmd.act && (cmd.act_kind != ACT_APPEND_NEVER))
        begin
            if (is_append)
            begin
                res_vci_reg    <= '0;
                res_status_reg <= cond ? RSP_RETURNED : RSP_IGNORED;
            end
            else
            begin
                res_vci_reg    <= cond ? VCI_W'(op_addr_reg) : '0;
                res_status_reg <= cond ? RSP_GRANTED : RSP_REFUSED;
            end
        end
        if (cmd.out_load)
        begin
            out_vci_reg    <= res_vci_reg;
            out_status_reg <= res_status_reg;
        end
    end

    assign sts.func           = func_reg;
    assign sts.need_refill    = (TW'(count_reg) < TW'(thr_reg));
    assign sts.cursor_lt_stop = (cursor_reg < stop_reg);
    assign sts.list_nonempty  = (count_reg != '0);
    assign sts.clr_last       = (clr_reg == IW'(VCI_SPACE - 1));

    assign out_vci    = out_vci_reg;
    assign out_status = out_status_reg;

endmodule

// ===== design/vfla_ctrl.sv =====
// Controller of the allocator: sequences status clearing, refill, list updates and
// the response handshake. Depends on vfla_pkg for the command and status structs.
module vfla_ctrl import vfla_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    output logic    out_valid,
    input  logic    out_ready,
    input  dp_sts_t sts,
    output dp_cmd_t cmd
);

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_DECODE,
        S_REF_CHK,
        S_REF_LOOP,
        S_REF_ACT,
        S_GRANT,
        S_ALLOC_ACT,
        S_SPEC_RD,
        S_SPEC_ACT,
        S_RET_RD,
        S_RET_ACT,
        S_DONE
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        cmd.rd_sel = RD_HEAD;
        cmd.act_kind = ACT_UNLINK_ANY;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clr = 1'b1;
                if (sts.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                case (sts.func)
                    FUNC_ALLOC:    state_next = S_REF_CHK;
                    FUNC_SPECIFIC: state_next = S_SPEC_RD;
                    FUNC_RETURN:   state_next = S_RET_RD;
                    default:
                    begin
                        cmd.res_refuse = 1'b1;
                        state_next = S_DONE;
                    end
                endcase
            end
            S_REF_CHK:
            begin
                if (sts.need_refill)
                begin
                    cmd.ref_start = 1'b1;
                    state_next = S_REF_LOOP;
                end
                else
                begin
                    state_next = S_GRANT;
                end
            end
            S_REF_LOOP:
            begin
                if (sts.cursor_lt_stop)
                begin
                    cmd.rd = 1'b1;
                    cmd.rd_sel = RD_CURSOR;
                    state_next = S_REF_ACT;
                end
                else
                begin
                    state_next = S_GRANT;
                end
            end
            S_REF_ACT:
            begin
                cmd.act = 1'b1;
                cmd.act_kind = ACT_APPEND_NEVER;
                cmd.cur_inc = 1'b1;
                state_next = S_REF_LOOP;
            end
            S_GRANT:
            begin
                if (sts.list_nonempty)
                begin
                    cmd.rd = 1'b1;
                    cmd.rd_sel = RD_HEAD;
                    state_next = S_ALLOC_ACT;
                end
                else
                begin
                    cmd.res_refuse = 1'b1;
                    state_next = S_DONE;
                end
            end
            S_ALLOC_ACT:
            begin
                cmd.act = 1'b1;
                cmd.act_kind = ACT_UNLINK_ANY;
                state_next = S_DONE;
            end
            S_SPEC_RD:
            begin
                cmd.rd = 1'b1;
                cmd.rd_sel = RD_VCI;
                state_next = S_SPEC_ACT;
            end
            S_SPEC_ACT:
            begin
                cmd.act = 1'b1;
                cmd.act_kind = ACT_UNLINK_FREE;
                state_next = S_DONE;
            end
            S_RET_RD:
            begin
                cmd.rd = 1'b1;
                cmd.rd_sel = RD_VCI;
                state_next = S_RET_ACT;
            end
            S_RET_ACT:
            begin
                cmd.act = 1'b1;
                cmd.act_kind = ACT_APPEND_USED;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule

// ===== design/vci_free_list_allocator.sv =====
// Connection identifier allocator with an ordered free list; top level.
// Request to response: a specific request or a return reads the entry of its identifier and
// then acts on it; an allocate first checks the refill threshold, then reads and unlinks the
// list head; a refill reads each candidate identifier in turn and appends it if never issued.
// One transaction is in work at a time; the response register lets the next request in.
// After reset the status memory is cleared, one entry a cycle over all VCI_SPACE entries,
// with the request channel not ready; configuration writes are taken meanwhile.
module vci_free_list_allocator import vfla_pkg::*;
#(
    parameter int VCI_SPACE    = VCI_SPACE_DEF,
    parameter int REFILL_BATCH = REFILL_BATCH_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    vfla_req_if.sink              req,
    vfla_rsp_if.source            rsp
);

    dp_cmd_t cmd;
    dp_sts_t sts;

    vfla_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    vfla_dp #(
        .VCI_SPACE    (VCI_SPACE),
        .REFILL_BATCH (REFILL_BATCH)
    ) u_dp
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_func    (req.func),
        .in_vci     (req.vci),
        .cmd        (cmd),
        .sts        (sts),
        .out_vci    (rsp.granted_vci),
        .out_status (rsp.status)
    );

endmodule

// ===== tb/vci_free_list_allocator_tb.sv =====
`timescale 1ns / 100ps
// Testbench for vci_free_list_allocator: directed and random request streams with a
// free-list predictor that checks every response. Depends on vfla_pkg and both channel interfaces.
module vci_free_list_allocator_tb;
    import vfla_pkg::*;

    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int SETTLE_TICKS = 8;
    localparam int ID_COUNT     = VCI_SPACE_DEF;
    localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

    typedef struct packed {
        logic [VCI_W-1:0] granted_vci;
        rsp_status_t      status;
    } alloc_result_t;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    vfla_req_if req_ch ();
    vfla_rsp_if rsp_ch ();

    vci_free_list_allocator dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req       (req_ch),
        .rsp       (rsp_ch)
    );

    always #5 clk = ~clk;

    vci_state_t       id_state [ID_COUNT];
    logic [VCI_W-1:0] next_id [ID_COUNT];
    logic [VCI_W-1:0] prev_id [ID_COUNT];
    logic [VCI_W-1:0] head_id;
    logic [VCI_W-1:0] tail_id;
    int unsigned      free_cnt;
    int unsigned      unissued;
    logic [VCI_W-1:0] base_reg;
    logic [THR_W-1:0] thr_reg;
    logic [VCI_W-1:0] held_ids [$];

    alloc_result_t pending_results [$];
    bit            failed = 1'b0;
    int            src_idle_pct = 0;
    int            snk_idle_pct = 0;
    int unsigned   cycle_count = 0;

    function automatic void reset_model();
        for (int i = 0; i < ID_COUNT; i++)
        begin
            id_state[i] = VS_NEVER;
            next_id[i] = '0;
            prev_id[i] = '0;
        end
        head_id = '0;
        tail_id = '0;
        free_cnt = 0;
        base_reg = VCI_BASE_RST;
        thr_reg = REFILL_THR_RST;
        unissued = int'(base_reg) + 1;
        held_ids.delete();
    endfunction

    function automatic void append_free(input logic [VCI_W-1:0] id);
        if (free_cnt == 0)
        begin
            head_id = id;
        end
        else
        begin
            next_id[tail_id] = id;
            prev_id[id] = tail_id;
        end
        tail_id = id;
        free_cnt++;
        id_state[id] = VS_FREE;
    endfunction

    function automatic void unlink_free(input logic [VCI_W-1:0] id);
        logic [VCI_W-1:0] p;
        logic [VCI_W-1:0] n;
        p = prev_id[id];
        n = next_id[id];
        if (free_cnt <= 1)
        begin
            head_id = '0;
            tail_id = '0;
            free_cnt = 0;
            return;
        end
        if (id == head_id)
            head_id = n;
        else
            next_id[p] = n;
        if (id == tail_id)
            tail_id = p;
        else
            prev_id[n] = p;
        free_cnt--;
    endfunction

    function automatic void refill_free_list();
        int unsigned stop;
        stop = unissued + REFILL_BATCH_DEF;
        if (stop > ID_COUNT)
            stop = ID_COUNT;
        for (int unsigned i = unissued; i < stop; i++)
        begin
            if (id_state[i] == VS_NEVER)
                append_free(VCI_W'(i));
        end
        unissued = stop;
    endfunction

    function automatic void drop_held(input logic [VCI_W-1:0] id);
        for (int i = 0; i < held_ids.size(); i++)
        begin
            if (held_ids[i] == id)
            begin
                held_ids.delete(i);
                break;
            end
        end
    endfunction

    function automatic alloc_result_t predict_allocator(input logic [FUNC_W-1:0] f,
                                                        input logic [VCI_W-1:0] id);
        alloc_result_t res;
        res.granted_vci = '0;
        res.status = RSP_REFUSED;
        case (f)
            FUNC_ALLOC:
            begin
                if (free_cnt < int'(thr_reg))
                    refill_free_list();
                if (free_cnt > 0)
                begin
                    res.granted_vci = head_id;
                    unlink_free(head_id);
                    id_state[res.granted_vci] = VS_USED;
                    held_ids.push_back(res.granted_vci);
                    res.status = RSP_GRANTED;
                end
            end
            FUNC_SPECIFIC:
            begin
                if (id_state[id] == VS_FREE)
                begin
                    unlink_free(id);
                    id_state[id] = VS_USED;
                    held_ids.push_back(id);
                    res.granted_vci = id;
                    res.status = RSP_GRANTED;
                end
            end
            FUNC_RETURN:
            begin
                if (id_state[id] == VS_USED)
                begin
                    append_free(id);
                    drop_held(id);
                    res.status = RSP_RETURNED;
                end
                else
                begin
                    res.status = RSP_IGNORED;
                end
            end
            default:
            begin
                res.status = RSP_REFUSED;
            end
        endcase
        return res;
    endfunction

    function automatic logic [VCI_W-1:0] pick_free_id();
        logic [VCI_W-1:0] id;
        int steps;
        if (free_cnt == 0)
            return VCI_W'($urandom_range(ID_COUNT - 1));
        steps = $urandom_range(63);
        id = head_id;
        for (int i = 0; i < steps && i < int'(free_cnt) - 1; i++)
            id = next_id[id];
        return id;
    endfunction

    function automatic logic [VCI_W-1:0] pick_held_id();
        if (held_ids.size() == 0)
            return VCI_W'($urandom_range(ID_COUNT - 1));
        return held_ids[$urandom_range(held_ids.size() - 1)];
    endfunction

    always @(negedge clk)
    begin
        rsp_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
    end

    always @(posedge clk)
    begin : monitor
        alloc_result_t want;
        if (rst_n)
        begin
            if (cfg_we)
            begin
                if (cfg_index == CFG_VCI_BASE)
                begin
                    base_reg = cfg_data[VCI_W-1:0];
                    unissued = int'(base_reg) + 1;
                end
                else if (cfg_index == CFG_REFILL_THR)
                begin
                    thr_reg = cfg_data[THR_W-1:0];
                end
            end
            if (req_ch.valid && req_ch.ready)
                pending_results.push_back(predict_allocator(req_ch.func, req_ch.vci));
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                if (pending_results.size() == 0)
                begin
                    $error("unexpected transaction: granted_vci %0d, status %0d",
                           rsp_ch.granted_vci, rsp_ch.status);
                    failed = 1'b1;
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (rsp_ch.granted_vci !== want.granted_vci)
                    begin
                        $error("granted_vci: expected %0d, actual %0d",
                               want.granted_vci, rsp_ch.granted_vci);
                        failed = 1'b1;
                    end
                    if (rsp_ch.status !== want.status)
                    begin
                        $error("status: expected %0d, actual %0d", want.status, rsp_ch.status);
                        failed = 1'b1;
                    end
                end
            end
        end
    end

    task automatic send_request(input logic [FUNC_W-1:0] f, input logic [VCI_W-1:0] id);
        while ($urandom_range(99) < src_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(negedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.func <= f;
        req_ch.vci <= id;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic drain_results();
        req_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (SETTLE_TICKS) @(negedge clk);
    endtask

    task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input int value);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= CFG_DATA_W'(value);
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    task automatic test_empty_list();
        write_cfg(CFG_VCI_BASE, 4094);
        write_cfg(CFG_REFILL_THR, 0);
        send_request(FUNC_ALLOC, 12'hFFF);
        drain_results();
        write_cfg(CFG_REFILL_THR, 4096);
        send_request(FUNC_ALLOC, 12'h000);
        send_request(FUNC_ALLOC, 12'hAAA);
        send_request(FUNC_RETURN, 12'hFFF);
        send_request(FUNC_RETURN, 12'hFFF);
        send_request(FUNC_SPECIFIC, 12'hFFF);
        send_request(FUNC_UNUSED, 12'hFFF);
        drain_results();
    endtask

    task automatic test_list_ops();
        write_cfg(CFG_VCI_BASE, 31);
        write_cfg(CFG_REFILL_THR, 16);
        send_request(FUNC_ALLOC, 12'h555);
        send_request(FUNC_SPECIFIC, 12'd40);
        send_request(FUNC_SPECIFIC, 12'd95);
        send_request(FUNC_SPECIFIC, 12'd33);
        send_request(FUNC_SPECIFIC, 12'd0);
        send_request(FUNC_SPECIFIC, 12'd200);
        send_request(FUNC_SPECIFIC, 12'd40);
        send_request(FUNC_RETURN, 12'd40);
        send_request(FUNC_RETURN, 12'd300);
        send_request(FUNC_RETURN, 12'd0);
        send_request(FUNC_UNUSED, 12'd0);
        send_request(FUNC_ALLOC, 12'd0);
        drain_results();
    endtask

    task automatic test_refill_overlap();
        write_cfg(CFG_VCI_BASE, 0);
        write_cfg(CFG_REFILL_THR, 4096);
        send_request(FUNC_ALLOC, 12'hFFF);
        send_request(FUNC_SPECIFIC, 12'd1);
        send_request(FUNC_RETURN, 12'hFFF);
        drain_results();
    endtask

    task automatic test_random(input int n_items, input int src_pct, input int snk_pct,
                               input int base, input int thr);
        int sel;
        src_idle_pct = src_pct;
        snk_idle_pct = snk_pct;
        write_cfg(CFG_VCI_BASE, base);
        write_cfg(CFG_REFILL_THR, thr);
        for (int i = 0; i < n_items; i++)
        begin
            sel = $urandom_range(99);
            if (sel < 45)
                send_request(FUNC_ALLOC, VCI_W'($urandom_range(ID_COUNT - 1)));
            else if (sel < 60)
                send_request(FUNC_SPECIFIC, pick_free_id());
            else if (sel < 85)
                send_request(FUNC_RETURN, pick_held_id());
            else if (sel < 92)
                send_request(FUNC_SPECIFIC, VCI_W'($urandom_range(ID_COUNT - 1)));
            else if (sel < 97)
                send_request(FUNC_RETURN, VCI_W'($urandom_range(ID_COUNT - 1)));
            else
                send_request(FUNC_UNUSED, VCI_W'($urandom_range(ID_COUNT - 1)));
        end
        drain_results();
    endtask

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("vci_free_list_allocator: mismatch");
        $finish;
    end

    initial
    begin
        reset_model();
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = CFG_VCI_BASE;
        cfg_data = '0;
        req_ch.valid = 1'b0;
        req_ch.func = FUNC_ALLOC;
        req_ch.vci = '0;
        rsp_ch.ready = 1'b0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_empty_list();
        test_list_ops();
        test_refill_overlap();
        test_random(600, 24, 83, $urandom_range(1, 200), $urandom_range(1, 80));
        test_random(600, 83, 24, $urandom_range(1000, 3900), 4096);
        test_random(550, 0, 0, 0, $urandom_range(0, 300));

        repeat (20) @(negedge clk);
        if (!failed && pending_results.size() == 0)
            $display("vci_free_list_allocator: match");
        else
            $display("vci_free_list_allocator: mismatch");
        $finish;
    end
endmodule
